>>> src/fwrm_pkg.sv
// Package for the queue with running mean: transaction types, request and status codes,
// and the layout of one stored entry. No dependencies.
package fwrm_pkg;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

    localparam int VALUE_W = 16;
    localparam int MEAN_W  = 24;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;
    localparam int FRAC_W  = 8;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [VALUE_W-1:0]  popped_value;
        logic [COUNT_W-1:0]         entry_count;
        logic signed [MEAN_W-1:0]   mean_q8;
        logic [TIME_W-1:0]          head_time;
        logic                       head_valid;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]          stamp;
        logic signed [VALUE_W-1:0]  value;
    } t_entry;

endpackage

>>> src/fwrm_store.sv
// Entry store of the queue: one synchronous memory of value and timestamp pairs.
// One write port, one read port with registered data. Depends on fwrm_pkg.
module fwrm_store #(
    parameter int DEPTH = 64,
    parameter int PW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [PW-1:0]    i_waddr,
    input  fwrm_pkg::t_entry i_wdata,
    input  logic             i_re,
    input  logic [PW-1:0]    i_raddr,
    output fwrm_pkg::t_entry o_rdata
);

    fwrm_pkg::t_entry r_mem [DEPTH];
    fwrm_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fwrm_div.sv
// Restoring divider for the mean: (sum * 256) / count, truncated toward zero,
// one quotient bit per cycle. Depends on fwrm_pkg.
module fwrm_div #(
    parameter int SW = 23,
    parameter int OW = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [SW-1:0]              i_sum,
    input  logic [OW-1:0]                     i_count,
    output logic                              o_done,
    output logic signed [fwrm_pkg::MEAN_W-1:0] o_mean
);

    localparam int NUMW = SW + fwrm_pkg::FRAC_W;
    localparam int CW   = $clog2(NUMW);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;
    logic [NUMW-1:0] r_num;
    logic [OW-1:0]   r_rem;
    logic [OW-1:0]   r_div;

    logic [SW-1:0]   mag;
    logic [OW:0]     rem_sh;
    logic            fits;
    logic [fwrm_pkg::MEAN_W-1:0] quot;

    assign mag    = i_sum[SW-1] ? SW'(-i_sum) : i_sum;
    assign rem_sh = {r_rem, r_num[NUMW-1]};
    assign fits   = rem_sh >= {1'b0, r_div};
    assign quot   = r_num[fwrm_pkg::MEAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_sum[SW-1];
                r_num  <= {mag, {fwrm_pkg::FRAC_W{1'b0}}};
                r_rem  <= '0;
                r_div  <= i_count;
            end else if (r_busy) begin
                r_rem <= fits ? OW'(rem_sh - {1'b0, r_div}) : rem_sh[OW-1:0];
                r_num <= {r_num[NUMW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUMW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_mean = r_neg ? -$signed(quot) : $signed(quot);

endmodule

>>> src/fifo_with_running_mean_unit.sv
// Top level of the queue with running mean: request sequencer, pointers, running sum
// and output register. Depends on fwrm_pkg, fwrm_store and fwrm_div.
//
// Usage. Requests arrive on the input channel (i_in_valid, o_in_ready, i_in_data) as
// one transaction each: a push of a signed 16-bit value, a pop of the head entry, or
// a one-millisecond tick. Every request yields exactly one result transaction on the
// output channel (o_out_valid, i_out_ready, o_out_data) carrying the status, the
// popped value, the entry count, the mean in signed Q.8 and the head timestamp.
// The block works on one request at a time. A request is accepted in S_IDLE; a pop
// that reads the store passes through S_POP; the head entry is read in S_HEAD; the
// bit-serial divider then works out SUM_W + 8 quotient bits (31 at the default depth
// of 64) in S_DIV; and S_OUT loads the output register. A request that leaves the
// queue empty skips the divider and S_DIV.
// The result sits in an output register, so a stalled receiver does not hold up the
// next request until that request's own result is ready to be written; it then
// waits until the previous result has been taken.
// Reset (synchronous, active low) empties the queue and clears the millisecond
// clock and the running sum; the entry store itself is not cleared, as data from
// unoccupied entries is never used.
module fifo_with_running_mean_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fwrm_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fwrm_pkg::t_out_item  o_out_data
);

    // Pointer, occupancy and running sum widths all follow from the depth.
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = fwrm_pkg::VALUE_W + OCC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_HEAD,
        S_DIV,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic [PTR_W-1:0]           r_rd_ptr;
    logic [PTR_W-1:0]           r_wr_ptr;
    logic [OCC_W-1:0]           r_occ;
    logic signed [SUM_W-1:0]    r_sum;
    logic [fwrm_pkg::TIME_W-1:0] r_ms_clock;
    logic [1:0]                 r_status;
    logic signed [fwrm_pkg::VALUE_W-1:0] r_popped;
    logic signed [fwrm_pkg::MEAN_W-1:0]  r_mean;
    logic                       r_out_valid;
    fwrm_pkg::t_out_item        r_out_data;

    logic                       in_fire;
    logic                       full;
    logic                       mem_we;
    logic                       mem_re;
    fwrm_pkg::t_entry           mem_wdata;
    fwrm_pkg::t_entry           mem_rdata;
    logic                       div_start;
    logic                       div_done;
    logic signed [fwrm_pkg::MEAN_W-1:0] div_mean;
    logic [PTR_W-1:0]           rd_ptr_next;
    logic [PTR_W-1:0]           wr_ptr_next;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign full       = r_occ >= OCC_W'(QUEUE_DEPTH);

    // Pointers wrap at the depth, which need not be a power of two.
    assign rd_ptr_next = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign wr_ptr_next = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;

    // A push writes its entry in the cycle it is accepted. A pop reads the head in
    // that same cycle; the head entry after the request is read in S_HEAD, always a
    // later cycle than any write, so no forwarding is needed.
    assign mem_we          = in_fire && (i_in_data.req_type == fwrm_pkg::REQ_PUSH) && !full;
    assign mem_wdata.stamp = r_ms_clock;
    assign mem_wdata.value = i_in_data.value;
    assign mem_re          = (in_fire && (i_in_data.req_type == fwrm_pkg::REQ_POP)
                              && (r_occ != '0)) || (r_state == S_HEAD);

    assign div_start = (r_state == S_HEAD) && (r_occ != '0);

    fwrm_store #(
        .DEPTH (QUEUE_DEPTH),
        .PW    (PTR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    fwrm_div #(
        .SW (SUM_W),
        .OW (OCC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_sum),
        .i_count (r_occ),
        .o_done  (div_done),
        .o_mean  (div_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_occ       <= '0;
            r_sum       <= '0;
            r_ms_clock  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A result taken while the next one is being loaded is replaced in S_OUT.
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_in_data.req_type)
                            fwrm_pkg::REQ_PUSH: begin
                                r_popped <= '0;
                                r_state  <= S_HEAD;
                                if (full) begin
                                    r_status <= fwrm_pkg::ST_PUSH_FULL;
                                end else begin
                                    r_status <= fwrm_pkg::ST_OK;
                                    r_wr_ptr <= wr_ptr_next;
                                    r_occ    <= r_occ + 1'b1;
                                    r_sum    <= r_sum + SUM_W'(i_in_data.value);
                                end
                            end
                            fwrm_pkg::REQ_POP: begin
                                if (r_occ == '0) begin
                                    r_status <= fwrm_pkg::ST_POP_EMPTY;
                                    r_popped <= '1;
                                    r_state  <= S_HEAD;
                                end else begin
                                    r_status <= fwrm_pkg::ST_OK;
                                    r_state  <= S_POP;
                                end
                            end
                            fwrm_pkg::REQ_TICK: begin
                                r_status   <= fwrm_pkg::ST_OK;
                                r_popped   <= '0;
                                r_state    <= S_HEAD;
                                r_ms_clock <= r_ms_clock + 1'b1;
                            end
                            default: begin
                                r_status <= fwrm_pkg::ST_OK;
                                r_popped <= '0;
                                r_state  <= S_HEAD;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    // The head read issued at acceptance is now in the read register.
                    r_popped <= mem_rdata.value;
                    r_rd_ptr <= rd_ptr_next;
                    r_occ    <= r_occ - 1'b1;
                    r_sum    <= (r_occ == OCC_W'(1)) ? '0
                                : r_sum - SUM_W'(mem_rdata.value);
                    r_state  <= S_HEAD;
                end
                S_HEAD: begin
                    r_mean  <= '0;
                    r_state <= (r_occ != '0) ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_mean  <= div_mean;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_data.status       <= r_status;
                        r_out_data.popped_value <= r_popped;
                        r_out_data.entry_count  <= fwrm_pkg::COUNT_W'(r_occ);
                        r_out_data.mean_q8      <= r_mean;
                        r_out_data.head_time    <= (r_occ != '0) ? mem_rdata.stamp : '0;
                        r_out_data.head_valid   <= (r_occ != '0);
                        r_out_valid             <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> verif/tb_fifo_with_running_mean_unit.sv
// Self-checking testbench for fifo_with_running_mean_unit: a scoreboard class predicts
// one report per request, while plain tasks drive the request channel and a separate process drives output ready.
// Depends on fwrm_pkg and on the block's top level.
module tb_fifo_with_running_mean_unit;

    // The block is built at its default depth; the predictor must agree with it.
    localparam int DEPTH        = 64;
    // Request code 3 is not used by the block and must behave as a no-op.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1500;
    // Long hold-off of the receiver, long enough for the block to back up its input.
    localparam int HOLD_CYCLES  = 400;
    // Worst case is roughly 1500 items times (the block's time per request plus two of the longest
    // gaps), then taken about three times over.
    localparam int LIMIT        = 1_000_000;
    localparam int SETTLE       = 60;

    typedef enum {FILL_UP, DRAIN_DOWN, CHURN} t_phase;
    typedef enum {ANY_VALUE, TOP_VALUES, BOTTOM_VALUES, NEAR_ZERO} t_value_style;

    // The scoreboard keeps its own copy of the queue and turns every accepted request
    // into the report that the block should return for it.
    class report_checker;
        logic signed [fwrm_pkg::VALUE_W-1:0] value_mem [DEPTH];
        logic [fwrm_pkg::TIME_W-1:0]         stamp_mem [DEPTH];
        int unsigned               rd_idx;
        int unsigned               wr_idx;
        int unsigned               fill;
        longint                    level_sum;
        logic [fwrm_pkg::TIME_W-1:0]         ms_now;
        fwrm_pkg::t_out_item       reports_due [$];
        int                        failures;
        int                        n_push, n_pop, n_tick, n_unused;
        int                        n_full, n_empty, n_checked;
        int unsigned               peak_fill;

        function new();
            rd_idx    = 0;
            wr_idx    = 0;
            fill      = 0;
            level_sum = 0;
            ms_now    = '0;
            failures  = 0;
            n_push = 0; n_pop = 0; n_tick = 0; n_unused = 0;
            n_full = 0; n_empty = 0; n_checked = 0;
            peak_fill = 0;
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        function void note_request(fwrm_pkg::t_in_item rq);
            fwrm_pkg::t_out_item rep;
            longint    mean_full;
            rep = '0;
            case (rq.req_type)
                fwrm_pkg::REQ_PUSH: begin
                    n_push++;
                    if (fill >= DEPTH) begin
                        // A push into a full queue is dropped and leaves the state alone.
                        rep.status = fwrm_pkg::ST_PUSH_FULL;
                        n_full++;
                    end else begin
                        value_mem[wr_idx] = rq.value;
                        stamp_mem[wr_idx] = ms_now;
                        wr_idx    = (wr_idx + 1) % DEPTH;
                        fill++;
                        level_sum += longint'(rq.value);
                    end
                end
                fwrm_pkg::REQ_POP: begin
                    n_pop++;
                    if (fill == 0) begin
                        rep.status       = fwrm_pkg::ST_POP_EMPTY;
                        rep.popped_value = -16'sd1;
                        n_empty++;
                    end else begin
                        rep.popped_value = value_mem[rd_idx];
                        rd_idx    = (rd_idx + 1) % DEPTH;
                        fill--;
                        level_sum -= longint'(rep.popped_value);
                        if (fill == 0)
                            level_sum = 0;
                    end
                end
                fwrm_pkg::REQ_TICK: begin
                    n_tick++;
                    ms_now = ms_now + 1'b1;
                end
                default: begin
                    n_unused++;
                end
            endcase
            if (fill > peak_fill)
                peak_fill = fill;
            rep.entry_count = fill[fwrm_pkg::COUNT_W-1:0];
            if (fill > 0) begin
                // Signed division in SystemVerilog truncates toward zero, as required.
                mean_full       = (level_sum * 256) / longint'(fill);
                rep.mean_q8     = mean_full[fwrm_pkg::MEAN_W-1:0];
                rep.head_time   = stamp_mem[rd_idx];
                rep.head_valid  = 1'b1;
            end
            reports_due.push_back(rep);
        endfunction

        function void check_report(fwrm_pkg::t_out_item got);
            fwrm_pkg::t_out_item want;
            if (reports_due.size() == 0) begin
                $error("result transaction with no request waiting for it");
                failures++;
                return;
            end
            want = reports_due.pop_front();
            n_checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.popped_value !== want.popped_value) begin
                $error("popped_value: expected %0d, actual %0d",
                       want.popped_value, got.popped_value);
                failures++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d",
                       want.entry_count, got.entry_count);
                failures++;
            end
            if (got.mean_q8 !== want.mean_q8) begin
                $error("mean_q8: expected %0d, actual %0d", want.mean_q8, got.mean_q8);
                failures++;
            end
            if (got.head_time !== want.head_time) begin
                $error("head_time: expected %0d, actual %0d",
                       want.head_time, got.head_time);
                failures++;
            end
            if (got.head_valid !== want.head_valid) begin
                $error("head_valid: expected %0d, actual %0d",
                       want.head_valid, got.head_valid);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    fwrm_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    fwrm_pkg::t_out_item o_out_data;

    report_checker board = new();
    int            cycle_count = 0;
    // Counted up by the sender to ask the receiver for its long hold-off.
    int            stall_asked = 0;

    fifo_with_running_mean_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a run that has not finished by the limit has hung somewhere.
    initial begin
        wait (cycle_count >= LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Result monitor. Outputs are sampled at the rising edge, before the block's own
    // updates for that edge take effect, so each result transaction is seen once.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_report(o_out_data);
    end

    // Gap lengths: usually none or a few cycles, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic fwrm_pkg::t_in_item make_request(logic [1:0] kind, int val);
        fwrm_pkg::t_in_item it;
        it.req_type = kind;
        it.value    = val[fwrm_pkg::VALUE_W-1:0];
        return it;
    endfunction

    // Random requests are weighted by phase, so that the queue is driven right up to
    // full and right down to empty over and over, with the pointers wrapping.
    function automatic fwrm_pkg::t_in_item pick_request(t_phase ph, t_value_style vs);
        int         r;
        int         s;
        logic [1:0] kind;
        r = $urandom_range(0, 99);
        case (ph)
            FILL_UP:
                kind = (r < 78) ? fwrm_pkg::REQ_PUSH : (r < 90) ? fwrm_pkg::REQ_POP :
                       (r < 97) ? fwrm_pkg::REQ_TICK : REQ_UNUSED;
            DRAIN_DOWN:
                kind = (r < 15) ? fwrm_pkg::REQ_PUSH : (r < 85) ? fwrm_pkg::REQ_POP :
                       (r < 96) ? fwrm_pkg::REQ_TICK : REQ_UNUSED;
            default:
                kind = (r < 42) ? fwrm_pkg::REQ_PUSH : (r < 80) ? fwrm_pkg::REQ_POP :
                       (r < 95) ? fwrm_pkg::REQ_TICK : REQ_UNUSED;
        endcase
        case (vs)
            TOP_VALUES:    s = 32767 - int'($urandom_range(0, 3));
            BOTTOM_VALUES: s = -32768 + int'($urandom_range(0, 3));
            NEAR_ZERO:     s = int'($urandom_range(0, 16)) - 8;
            default:       s = int'($urandom);
        endcase
        return make_request(kind, s);
    endfunction

    // Offers one request from a falling edge and holds it until the block takes it.
    // On return the time is the falling edge after acceptance, so a follow-on request
    // can be presented straight away without dropping valid in between.
    task automatic send_request(fwrm_pkg::t_in_item it);
        i_in_data  = it;
        i_in_valid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        board.note_request(it);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Holds the sender back until every outstanding report has been returned.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
    endtask

    // Receiver: ready is changed only at falling edges. It mixes short and long
    // back-pressure with stretches of steady readiness, and serves the long
    // hold-off on request, counting the cycles here in its own process.
    initial begin
        int hold_left;
        int steady_left;
        int stall_served;
        hold_left    = 0;
        steady_left  = 0;
        stall_served = 0;
        i_out_ready  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_asked != stall_served) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                stall_served = stall_asked;
            end else if (steady_left > 0) begin
                i_out_ready = 1'b1;
                steady_left--;
            end else if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = 1'b1;
                if ($urandom_range(0, 99) < 2)
                    steady_left = $urandom_range(100, 300);
                else if ($urandom_range(0, 3) == 0)
                    hold_left = idle_len();
            end
        end
    end

    // Sender and overall sequencing.
    initial begin
        fwrm_pkg::t_in_item directed [$];
        fwrm_pkg::t_in_item rq;
        t_phase       phase;
        t_value_style style;
        int           issued;
        int           phase_len;
        bit           steady;
        bit           drained_once;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        issued       = 0;
        drained_once = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening: pops and no-ops on an empty queue, the value extremes,
        // timestamps that move with ticks, and draining back to empty.
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  16'h1234));
        directed.push_back(make_request(REQ_UNUSED,         0));
        directed.push_back(make_request(fwrm_pkg::REQ_TICK, 0));
        directed.push_back(make_request(fwrm_pkg::REQ_PUSH, 32767));
        directed.push_back(make_request(fwrm_pkg::REQ_PUSH, -32768));
        directed.push_back(make_request(fwrm_pkg::REQ_TICK, -1));
        directed.push_back(make_request(fwrm_pkg::REQ_PUSH, 0));
        directed.push_back(make_request(fwrm_pkg::REQ_PUSH, -1));
        directed.push_back(make_request(fwrm_pkg::REQ_TICK, 0));
        directed.push_back(make_request(fwrm_pkg::REQ_TICK, 32767));
        directed.push_back(make_request(fwrm_pkg::REQ_PUSH, 1));
        directed.push_back(make_request(REQ_UNUSED,         -32768));
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  0));
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  -1));
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  0));
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  0));
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  0));
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  0));
        directed.push_back(make_request(fwrm_pkg::REQ_PUSH, -32768));
        directed.push_back(make_request(fwrm_pkg::REQ_PUSH, -7));
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  0));
        directed.push_back(make_request(fwrm_pkg::REQ_POP,  0));
        foreach (directed[k]) begin
            pause_sender(idle_len());
            send_request(directed[k]);
        end
        wait_drained();

        // Random part in phases of random weighting, value style and idling.
        while (issued < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 120);
            case ($urandom_range(0, 2))
                0:       phase = FILL_UP;
                1:       phase = DRAIN_DOWN;
                default: phase = CHURN;
            endcase
            case ($urandom_range(0, 9))
                0, 1:    style = TOP_VALUES;
                2, 3:    style = BOTTOM_VALUES;
                4:       style = NEAR_ZERO;
                default: style = ANY_VALUE;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                if (issued == 400 || issued == 1100)
                    stall_asked++;
                if (issued == 750 && !drained_once) begin
                    drained_once = 1'b1;
                    wait_drained();
                end
                rq = pick_request(phase, style);
                pause_sender(steady ? 0 : idle_len());
                send_request(rq);
                // No-op requests do not count toward the amount of stimulus.
                if (rq.req_type != REQ_UNUSED)
                    issued++;
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d pushes (%0d on a full queue), %0d pops (%0d on an empty queue),",
                 board.n_push, board.n_full, board.n_pop, board.n_empty);
        $display("%0d ticks, %0d unused codes; peak occupancy %0d, %0d results checked.",
                 board.n_tick, board.n_unused, board.peak_fill, board.n_checked);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
